// File: rtl/jsld_pkg.sv
package jsld_pkg;

    // One byte of JSON text, or the end-of-text marker.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } text_item_t;

    // One decoded byte or one status report.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       last;
        logic [3:0] status;
    } dec_item_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_STR  = 4'd1,
        PH_ESC  = 4'd2,
        PH_HEX1 = 4'd3,
        PH_BS   = 4'd4,
        PH_U    = 4'd5,
        PH_HEX2 = 4'd6,
        PH_UTF  = 4'd7
    } phase_t;

    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_DONE          = 4'd1;
    localparam logic [3:0] ST_NO_QUOTE      = 4'd2;
    localparam logic [3:0] ST_CTRL_CHAR     = 4'd3;
    localparam logic [3:0] ST_TRUNC_ESC     = 4'd4;
    localparam logic [3:0] ST_BAD_ESC       = 4'd5;
    localparam logic [3:0] ST_TRUNC_HEX     = 4'd6;
    localparam logic [3:0] ST_BAD_HEX       = 4'd7;
    localparam logic [3:0] ST_MISSING_LOW   = 4'd8;
    localparam logic [3:0] ST_BAD_LOW       = 4'd9;
    localparam logic [3:0] ST_UNPAIRED_LOW  = 4'd10;
    localparam logic [3:0] ST_BAD_LEAD      = 4'd11;
    localparam logic [3:0] ST_TRUNC_UTF8    = 4'd12;
    localparam logic [3:0] ST_BAD_CONT      = 4'd13;
    localparam logic [3:0] ST_BAD_CODE      = 4'd14;
    localparam logic [3:0] ST_UNTERMINATED  = 4'd15;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Encoded UTF-8 group: byte count and bytes, first byte in slot 0.
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
    } utf8_enc_t;

    function automatic utf8_enc_t utf8_encode(input logic [20:0] n);
        utf8_enc_t e;
        e.bytes = '0;
        if (n < 21'h80) begin
            e.cnt      = 3'd1;
            e.bytes[0] = n[7:0];
        end
        else if (n < 21'h800) begin
            e.cnt      = 3'd2;
            e.bytes[0] = {3'b110, n[10:6]};
            e.bytes[1] = {2'b10, n[5:0]};
        end
        else if (n < 21'h10000) begin
            e.cnt      = 3'd3;
            e.bytes[0] = {4'b1110, n[15:12]};
            e.bytes[1] = {2'b10, n[11:6]};
            e.bytes[2] = {2'b10, n[5:0]};
        end
        else begin
            e.cnt      = 3'd4;
            e.bytes[0] = {5'b11110, n[20:18]};
            e.bytes[1] = {2'b10, n[17:12]};
            e.bytes[2] = {2'b10, n[11:6]};
            e.bytes[3] = {2'b10, n[5:0]};
        end
        return e;
    endfunction

    // {ok, value} of one hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// File: rtl/json_string_literal_decoder_core.sv
// Channel | Valid      | Stall      | Payload              | Carries
// text    | text_valid | text_stall | text_item (in)       | one JSON byte or end of text
// dec     | dec_valid  | dec_stall  | dec_item (out)       | one decoded byte or status
//
// An accepted item lands in the input register, where it is decoded; its
// results (up to four) are loaded into the result group register once it frees up.
// One new item is taken every cycle while dec is not stalled and each item
// yields at most one result. An item that yields k results holds the group
// register while it drains, one result a cycle unless dec stalls; that
// drain sets the peak rate.
// Reset clears the decoder state (idle, awaiting the opening quote) and
// empties both registers; there is no clearing pass.
// A stall on dec backs up into text_stall once the input register is full.
module json_string_literal_decoder_core
    import jsld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  text_item_t text_item,
    output logic       dec_valid,
    input  logic       dec_stall,
    output dec_item_t  dec_item
);

    // Input register.
    logic       in_valid_reg;
    text_item_t in_item_reg;

    // Decoder state.
    phase_t      phase_reg, phase_next;
    logic [20:0] code_acc_reg, code_next;
    logic [9:0]  high_half_reg, high_next;
    logic [2:0]  digits_left_reg, digits_next;
    logic [1:0]  seq_len_reg, seq_next;
    logic        st_clear;

    // Result group register.
    logic [2:0]      grp_cnt_reg;
    logic [1:0]      grp_idx_reg;
    logic [3:0]      grp_status_reg;
    logic [3:0][7:0] grp_bytes_reg;

    // Current results.
    logic        res_report;
    logic        res_emit;
    logic [3:0]  res_status;
    logic [20:0] emit_code;
    utf8_enc_t   enc;
    logic [2:0]  res_cnt;

    // Handshake.
    logic pop, grp_last, grp_free, consume;

    // Byte decode shared by both state blocks.
    logic [7:0]  c;
    logic        eot;
    logic        is_ws;
    logic [4:0]  hex;
    logic [15:0] hex_code;
    logic [2:0]  dl_dec;
    logic        hex_done;
    logic        hi_sur, lo_sur;
    logic [20:0] pair_code;
    logic [20:0] utf_code;
    logic [1:0]  sl_dec;
    logic        utf_done;
    logic [20:0] utf_min;
    logic        utf_bad;
    logic [1:0]  lead_len;
    logic [20:0] lead_bits;
    logic        cont_ok;
    logic        esc_ok, esc_u;
    logic [7:0]  esc_byte;

    assign c        = in_item_reg.in_byte;
    assign eot      = in_item_reg.end_of_text;
    assign is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    assign hex      = hex_digit(c);
    assign hex_code = {code_acc_reg[11:0], hex[3:0]};
    assign dl_dec   = digits_left_reg - 3'd1;
    assign hex_done = (dl_dec == 3'd0);
    assign hi_sur   = (hex_code >= 16'hd800) && (hex_code <= 16'hdbff);
    assign lo_sur   = (hex_code >= 16'hdc00) && (hex_code <= 16'hdfff);
    // 0x10000 + high * 1024 + (low - 0xDC00)
    assign pair_code = 21'h10000 + {1'b0, high_half_reg, hex_code[9:0]};

    assign utf_code = {code_acc_reg[14:0], c[5:0]};
    assign sl_dec   = seq_len_reg - 2'd1;
    assign utf_done = (sl_dec == 2'd0);
    assign cont_ok  = (c[7:6] == 2'b10);

    always_comb
    begin
        case (digits_left_reg)
            3'd1:    utf_min = 21'h80;
            3'd2:    utf_min = 21'h800;
            default: utf_min = 21'h10000;
        endcase
    end

    assign utf_bad = (utf_code < utf_min) || (utf_code > 21'h10ffff)
                   || ((utf_code >= 21'hd800) && (utf_code <= 21'hdfff));

    always_comb
    begin
        if (c >= 8'hc2 && c <= 8'hdf) begin
            lead_len = 2'd1;
        end
        else if (c >= 8'he0 && c <= 8'hef) begin
            lead_len = 2'd2;
        end
        else if (c >= 8'hf0 && c <= 8'hf4) begin
            lead_len = 2'd3;
        end
        else begin
            lead_len = 2'd0;
        end
    end

    always_comb
    begin
        case (lead_len)
            2'd1:    lead_bits = {16'd0, c[4:0]};
            2'd2:    lead_bits = {17'd0, c[3:0]};
            default: lead_bits = {18'd0, c[2:0]};
        endcase
    end

    // Short escapes map to one byte; \u starts a hex group.
    always_comb
    begin
        esc_ok   = 1'b1;
        esc_u    = 1'b0;
        esc_byte = c;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = c;
            CH_LOW_B: esc_byte = CH_BS;
            CH_LOW_F: esc_byte = CH_FF;
            CH_LOW_N: esc_byte = CH_LF;
            CH_LOW_R: esc_byte = CH_CR;
            CH_LOW_T: esc_byte = CH_TAB;
            CH_LOW_U:
            begin
                esc_ok = 1'b0;
                esc_u  = 1'b1;
            end
            default: esc_ok = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next  = phase_reg;
        code_next   = code_acc_reg;
        high_next   = high_half_reg;
        digits_next = digits_left_reg;
        seq_next    = seq_len_reg;
        st_clear    = 1'b0;
        if (eot) begin
            st_clear = 1'b1;
        end
        else begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (c == CH_QUOTE) begin
                        phase_next = PH_STR;
                    end
                    else if (!is_ws) begin
                        st_clear = 1'b1;
                    end
                end
                PH_STR:
                begin
                    if (c == CH_QUOTE || c < 8'h20) begin
                        st_clear = 1'b1;
                    end
                    else if (c == CH_BSLASH) begin
                        phase_next = PH_ESC;
                    end
                    else if (c >= 8'h80) begin
                        if (lead_len == 2'd0) begin
                            st_clear = 1'b1;
                        end
                        else begin
                            seq_next    = lead_len;
                            digits_next = {1'b0, lead_len};
                            code_next   = lead_bits;
                            phase_next  = PH_UTF;
                        end
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_STR;
                    if (esc_u) begin
                        phase_next  = PH_HEX1;
                        digits_next = 3'd4;
                        code_next   = '0;
                    end
                    else if (!esc_ok) begin
                        st_clear = 1'b1;
                    end
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (!hex[4]) begin
                        st_clear = 1'b1;
                    end
                    else begin
                        code_next   = {5'd0, hex_code};
                        digits_next = dl_dec;
                        if (hex_done) begin
                            if (phase_reg == PH_HEX1 && hi_sur) begin
                                high_next  = hex_code[9:0];
                                code_next  = '0;
                                phase_next = PH_BS;
                            end
                            else if ((phase_reg == PH_HEX1 && lo_sur)
                                     || (phase_reg == PH_HEX2 && !lo_sur)) begin
                                st_clear = 1'b1;
                            end
                            else begin
                                phase_next = PH_STR;
                                code_next  = '0;
                                high_next  = '0;
                            end
                        end
                    end
                end
                PH_BS:
                begin
                    if (c != CH_BSLASH) begin
                        st_clear = 1'b1;
                    end
                    else begin
                        phase_next = PH_U;
                    end
                end
                PH_U:
                begin
                    if (c != CH_LOW_U) begin
                        st_clear = 1'b1;
                    end
                    else begin
                        phase_next  = PH_HEX2;
                        digits_next = 3'd4;
                        code_next   = '0;
                    end
                end
                PH_UTF:
                begin
                    if (!cont_ok) begin
                        st_clear = 1'b1;
                    end
                    else begin
                        code_next = utf_code;
                        seq_next  = sl_dec;
                        if (utf_done) begin
                            if (utf_bad) begin
                                st_clear = 1'b1;
                            end
                            else begin
                                phase_next  = PH_STR;
                                code_next   = '0;
                                digits_next = '0;
                            end
                        end
                    end
                end
                default: st_clear = 1'b1;
            endcase
        end
        if (st_clear) begin
            phase_next  = PH_IDLE;
            code_next   = '0;
            high_next   = '0;
            digits_next = '0;
            seq_next    = '0;
        end
    end

    // Results of the item in the input register.
    always_comb
    begin
        res_report = 1'b0;
        res_emit   = 1'b0;
        res_status = ST_OK;
        emit_code  = '0;
        if (eot) begin
            res_report = 1'b1;
            case (phase_reg)
                PH_IDLE:          res_status = ST_NO_QUOTE;
                PH_ESC:           res_status = ST_TRUNC_ESC;
                PH_HEX1, PH_HEX2: res_status = ST_TRUNC_HEX;
                PH_BS, PH_U:      res_status = ST_MISSING_LOW;
                PH_UTF:           res_status = ST_TRUNC_UTF8;
                default:          res_status = ST_UNTERMINATED;
            endcase
        end
        else begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (c != CH_QUOTE && !is_ws) begin
                        res_report = 1'b1;
                        res_status = ST_NO_QUOTE;
                    end
                end
                PH_STR:
                begin
                    if (c == CH_QUOTE) begin
                        res_report = 1'b1;
                        res_status = ST_DONE;
                    end
                    else if (c < 8'h20) begin
                        res_report = 1'b1;
                        res_status = ST_CTRL_CHAR;
                    end
                    else if (c < 8'h80 && c != CH_BSLASH) begin
                        res_emit  = 1'b1;
                        emit_code = {13'd0, c};
                    end
                    else if (c >= 8'h80 && lead_len == 2'd0) begin
                        res_report = 1'b1;
                        res_status = ST_BAD_LEAD;
                    end
                end
                PH_ESC:
                begin
                    if (esc_ok) begin
                        res_emit  = 1'b1;
                        emit_code = {13'd0, esc_byte};
                    end
                    else if (!esc_u) begin
                        res_report = 1'b1;
                        res_status = ST_BAD_ESC;
                    end
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (!hex[4]) begin
                        res_report = 1'b1;
                        res_status = ST_BAD_HEX;
                    end
                    else if (hex_done) begin
                        if (phase_reg == PH_HEX1) begin
                            if (lo_sur) begin
                                res_report = 1'b1;
                                res_status = ST_UNPAIRED_LOW;
                            end
                            else if (!hi_sur) begin
                                res_emit  = 1'b1;
                                emit_code = {5'd0, hex_code};
                            end
                        end
                        else if (!lo_sur) begin
                            res_report = 1'b1;
                            res_status = ST_BAD_LOW;
                        end
                        else begin
                            res_emit  = 1'b1;
                            emit_code = pair_code;
                        end
                    end
                end
                PH_BS:
                begin
                    if (c != CH_BSLASH) begin
                        res_report = 1'b1;
                        res_status = ST_MISSING_LOW;
                    end
                end
                PH_U:
                begin
                    if (c != CH_LOW_U) begin
                        res_report = 1'b1;
                        res_status = ST_MISSING_LOW;
                    end
                end
                PH_UTF:
                begin
                    if (!cont_ok) begin
                        res_report = 1'b1;
                        res_status = ST_BAD_CONT;
                    end
                    else if (utf_done) begin
                        if (utf_bad) begin
                            res_report = 1'b1;
                            res_status = ST_BAD_CODE;
                        end
                        else begin
                            res_emit  = 1'b1;
                            emit_code = utf_code;
                        end
                    end
                end
                default:
                begin
                    res_report = 1'b0;
                end
            endcase
        end
    end

    assign enc     = utf8_encode(emit_code);
    assign res_cnt = res_report ? 3'd1 : (res_emit ? enc.cnt : 3'd0);

    // Drain the group one result a cycle while dec is not stalled; take the next
    // item once the group frees up, or at once when it yields nothing.
    assign dec_valid  = (grp_cnt_reg != 3'd0);
    assign pop        = dec_valid && !dec_stall;
    assign grp_last   = ({1'b0, grp_idx_reg} == grp_cnt_reg - 3'd1);
    assign grp_free   = !dec_valid || (pop && grp_last);
    assign consume    = in_valid_reg && ((res_cnt == 3'd0) || grp_free);
    assign text_stall = in_valid_reg && !consume;

    assign dec_item.status    = grp_status_reg;
    assign dec_item.out_valid = (grp_status_reg == ST_OK);
    assign dec_item.out_byte  = (grp_status_reg == ST_OK) ? grp_bytes_reg[grp_idx_reg] : 8'd0;
    assign dec_item.last      = grp_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (!text_stall) begin
            in_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall) begin
            in_item_reg <= text_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_IDLE;
            code_acc_reg    <= '0;
            high_half_reg   <= '0;
            digits_left_reg <= '0;
            seq_len_reg     <= '0;
        end
        else if (consume) begin
            phase_reg       <= phase_next;
            code_acc_reg    <= code_next;
            high_half_reg   <= high_next;
            digits_left_reg <= digits_next;
            seq_len_reg     <= seq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grp_cnt_reg <= '0;
            grp_idx_reg <= '0;
        end
        else if (consume && res_cnt != 3'd0) begin
            grp_cnt_reg <= res_cnt;
            grp_idx_reg <= '0;
        end
        else if (pop) begin
            if (grp_last) begin
                grp_cnt_reg <= '0;
                grp_idx_reg <= '0;
            end
            else begin
                grp_idx_reg <= grp_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && res_cnt != 3'd0) begin
            grp_status_reg <= res_report ? res_status : ST_OK;
            grp_bytes_reg  <= res_report ? '0 : enc.bytes;
        end
    end

`ifndef ASSERT_OFF
    a_grp_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        grp_cnt_reg <= 3'd4)
        else $error("result group count above four");

    a_grp_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid |-> ({1'b0, grp_idx_reg} < grp_cnt_reg))
        else $error("result index beyond group");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && grp_status_reg != ST_OK) |-> (grp_cnt_reg == 3'd1))
        else $error("status report not a single result");

    a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && res_report) |=> (phase_reg == PH_IDLE && code_acc_reg == 21'd0
                                     && high_half_reg == 10'd0))
        else $error("state not cleared after report");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && res_cnt != 3'd0) |-> grp_free)
        else $error("result group overwritten before drained");
`endif

endmodule
